// ----- hdl/edid_pkg.sv -----
// Shared constants and types for the EDID base block parser.
package edid_pkg;

  localparam int TEXT_CHARS = 13;
  localparam int CNT_W      = $clog2(TEXT_CHARS + 1);
  localparam int IDX_W      = (TEXT_CHARS > 1) ? $clog2(TEXT_CHARS) : 1;

  localparam int OUT_W      = 320;

  localparam logic [7:0] OFF_LAST_BYTE = 8'd127;
  localparam logic [7:0] OFF_DESC_BASE = 8'd54;
  localparam logic [7:0] OFF_DESC_END  = 8'd126;
  localparam logic [4:0] DESC_REL_LAST = 5'd17;
  localparam logic [4:0] DESC_REL_TAG  = 5'd3;
  localparam logic [4:0] DESC_REL_TEXT = 5'd5;

  localparam logic [7:0] TAG_NAME   = 8'hFC;
  localparam logic [7:0] TAG_SERIAL = 8'hFF;
  localparam logic [7:0] CH_NUL     = 8'h00;
  localparam logic [7:0] CH_LF      = 8'h0A;
  localparam logic [7:0] CH_SPACE   = 8'h20;
  localparam logic [7:0] CH_TILDE   = 8'h7E;
  localparam logic [11:0] YEAR_BASE = 12'd1990;

  typedef enum logic [2:0] {
    TGT_NONE   = 3'b001,
    TGT_NAME   = 3'b010,
    TGT_SERIAL = 3'b100
  } text_target_t;

  typedef struct packed {
    logic       clear;
    logic       take;
    logic [7:0] data;
  } text_ctl_t;

endpackage

// ----- hdl/edid_text_cap.sv -----
// Text string capture for one descriptor tag: character store, counts and packing.
module edid_text_cap
  import edid_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  text_ctl_t   ctl,
  output logic        stop,
  output logic [63:0] text_lo,
  output logic [39:0] text_hi
);

  logic [7:0]       chars_r [TEXT_CHARS];
  logic [CNT_W-1:0] count_r, count_nxt;
  logic [CNT_W-1:0] kept_r, kept_nxt;
  logic             wr_en;
  logic             terminator;
  logic             full;
  logic             printable;

  always_comb begin
    terminator = (ctl.data == CH_NUL) || (ctl.data == CH_LF);
    full       = count_r >= CNT_W'(TEXT_CHARS);
    printable  = (ctl.data >= CH_SPACE) && (ctl.data <= CH_TILDE);
    wr_en      = 1'b0;
    stop       = 1'b0;
    count_nxt  = count_r;
    kept_nxt   = kept_r;
    if (ctl.clear) begin
      count_nxt = '0;
      kept_nxt  = '0;
    end else if (ctl.take) begin
      if (terminator || full) begin
        stop = 1'b1;
      end else if (printable) begin
        wr_en     = 1'b1;
        count_nxt = count_r + 1'b1;
        // trailing spaces do not extend the kept length
        if (ctl.data != CH_SPACE) begin
          kept_nxt = count_r + 1'b1;
        end
        if (count_r + 1'b1 >= CNT_W'(TEXT_CHARS)) begin
          stop = 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r <= '0;
      kept_r  <= '0;
    end else begin
      count_r <= count_nxt;
      kept_r  <= kept_nxt;
    end
  end

  // Entries at or past the kept length are masked on output, so no clear is needed.
  always_ff @(posedge clk) begin
    if (wr_en) begin
      chars_r[count_r[IDX_W-1:0]] <= ctl.data;
    end
  end

  always_comb begin
    text_lo = '0;
    text_hi = '0;
    for (int k = 0; k < TEXT_CHARS; k++) begin
      if (CNT_W'(k) < kept_r) begin
        if (k < 8) begin
          text_lo[8*(k%8) +: 8] = chars_r[k];
        end else begin
          text_hi[8*((k-8)%5) +: 8] = chars_r[k];
        end
      end
    end
  end

endmodule

// ----- hdl/edid_base_block_parser_top.sv -----
// EDID base block parser: input register, byte field capture and result register.
// A result is loaded into the result register when its final byte leaves the input register.
// Throughput: one byte per cycle; a final byte waits only while the previous result is unread.
// The input register and the result register decouple both sides of the stream.
// Reset: rst_n is synchronous, active low, and clears all parser state and both stages.
// After each final byte all parser state returns to its reset value for the next block.
module edid_base_block_parser_top
  import edid_pkg::*;
(
  input  logic             clk,
  input  logic             rst_n,
  input  logic             in_tvalid,
  output logic             in_tready,
  input  logic [7:0]       in_tdata,   // [7:0] edid_byte
  input  logic             in_tlast,
  output logic             out_tvalid,
  input  logic             out_tready,
  // [23:0] maker_letters, [39:24] prod_id, [71:40] serial_id, [83:72] year,
  // [95:84] hsize, [107:96] vsize, [171:108] name_text_low,
  // [211:172] name_text_high, [275:212] serial_text_low, [315:276] serial_text_high
  output logic [OUT_W-1:0] out_tdata,
  output logic             out_tuser   // [0] valid_res
);

  logic       s1_valid_r, s1_last_r;
  logic [7:0] s1_byte_r;
  logic       s1_fire, out_free, take, blk_end, in_desc;

  logic [7:0]   offset_r, offset_nxt;
  logic         header_ok_r, header_ok_nxt;
  logic [14:0]  maker_r, maker_nxt;
  logic [15:0]  product_r, product_nxt;
  logic [31:0]  serial_r, serial_nxt;
  logic [7:0]   year_r, year_nxt;
  logic [7:0]   width_lo_r, width_lo_nxt;
  logic [3:0]   width_hi_r, width_hi_nxt;
  logic [7:0]   height_lo_r, height_lo_nxt;
  logic [3:0]   height_hi_r, height_hi_nxt;
  logic [4:0]   rel_r, rel_nxt;
  logic         prefix_zero_r, prefix_zero_nxt;
  text_target_t target_r, target_nxt;
  logic         stopped_r, stopped_nxt;

  text_ctl_t   name_ctl, serial_ctl;
  logic        name_stop, serial_stop;
  logic [63:0] name_lo, serial_lo;
  logic [39:0] name_hi, serial_hi;

  logic             out_valid_r, out_valid_nxt;
  logic [OUT_W-1:0] out_data_r;
  logic             out_user_r;
  logic             res_valid;
  logic [23:0]      letters;
  logic [11:0]      year_full;

  assign out_free  = !out_valid_r || out_tready;
  assign s1_fire   = s1_valid_r && (!s1_last_r || out_free);
  assign in_tready = !s1_valid_r || s1_fire;
  assign take      = s1_fire && !offset_r[7];
  assign blk_end   = s1_fire && s1_last_r;
  assign in_desc   = (offset_r >= OFF_DESC_BASE) && (offset_r < OFF_DESC_END);

  // input register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (in_tready) begin
      s1_valid_r <= in_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_tready && in_tvalid) begin
      s1_byte_r <= in_tdata;
      s1_last_r <= in_tlast;
    end
  end

  // text unit requests; text is taken only while the descriptor is still open
  always_comb begin
    name_ctl.data    = s1_byte_r;
    serial_ctl.data  = s1_byte_r;
    name_ctl.clear   = blk_end || (take && in_desc && rel_r == DESC_REL_TAG &&
                                   prefix_zero_r && s1_byte_r == TAG_NAME);
    serial_ctl.clear = blk_end || (take && in_desc && rel_r == DESC_REL_TAG &&
                                   prefix_zero_r && s1_byte_r == TAG_SERIAL);
    name_ctl.take    = take && in_desc && rel_r >= DESC_REL_TEXT && !stopped_r &&
                       target_r == TGT_NAME;
    serial_ctl.take  = take && in_desc && rel_r >= DESC_REL_TEXT && !stopped_r &&
                       target_r == TGT_SERIAL;
  end

  edid_text_cap u_name_cap (
    .clk     (clk),
    .rst_n   (rst_n),
    .ctl     (name_ctl),
    .stop    (name_stop),
    .text_lo (name_lo),
    .text_hi (name_hi)
  );

  edid_text_cap u_serial_cap (
    .clk     (clk),
    .rst_n   (rst_n),
    .ctl     (serial_ctl),
    .stop    (serial_stop),
    .text_lo (serial_lo),
    .text_hi (serial_hi)
  );

  always_comb begin
    offset_nxt      = offset_r;
    header_ok_nxt   = header_ok_r;
    maker_nxt       = maker_r;
    product_nxt     = product_r;
    serial_nxt      = serial_r;
    year_nxt        = year_r;
    width_lo_nxt    = width_lo_r;
    width_hi_nxt    = width_hi_r;
    height_lo_nxt   = height_lo_r;
    height_hi_nxt   = height_hi_r;
    rel_nxt         = rel_r;
    prefix_zero_nxt = prefix_zero_r;
    target_nxt      = target_r;
    stopped_nxt     = stopped_r;
    if (take) begin
      offset_nxt = offset_r + 8'd1;
      unique case (offset_r)
        8'd0:  if (s1_byte_r != 8'h00) header_ok_nxt = 1'b0;
        8'd1, 8'd2, 8'd3: if (s1_byte_r != 8'hFF) header_ok_nxt = 1'b0;
        8'd8:  maker_nxt[14:8]        = s1_byte_r[6:0];
        8'd9:  maker_nxt[7:0]         = s1_byte_r;
        8'd10: product_nxt[7:0]       = s1_byte_r;
        8'd11: product_nxt[15:8]      = s1_byte_r;
        8'd12: serial_nxt[7:0]        = s1_byte_r;
        8'd13: serial_nxt[15:8]       = s1_byte_r;
        8'd14: serial_nxt[23:16]      = s1_byte_r;
        8'd15: serial_nxt[31:24]      = s1_byte_r;
        8'd17: year_nxt               = s1_byte_r;
        8'd56: width_lo_nxt           = s1_byte_r;
        8'd58: width_hi_nxt           = s1_byte_r[7:4];
        8'd59: height_lo_nxt          = s1_byte_r;
        8'd61: height_hi_nxt          = s1_byte_r[7:4];
        default: ;
      endcase
      if (in_desc) begin
        priority if (rel_r == 5'd0) begin
          prefix_zero_nxt = (s1_byte_r == 8'h00);
          target_nxt      = TGT_NONE;
          stopped_nxt     = 1'b0;
        end else if (rel_r < DESC_REL_TAG) begin
          if (s1_byte_r != 8'h00) prefix_zero_nxt = 1'b0;
        end else if (rel_r == DESC_REL_TAG) begin
          if (prefix_zero_r && s1_byte_r == TAG_NAME) begin
            target_nxt = TGT_NAME;
          end else if (prefix_zero_r && s1_byte_r == TAG_SERIAL) begin
            target_nxt = TGT_SERIAL;
          end
        end else begin
          if (name_stop || serial_stop) stopped_nxt = 1'b1;
        end
        if (rel_r == DESC_REL_LAST) begin
          target_nxt = TGT_NONE;
          rel_nxt    = '0;
        end else begin
          rel_nxt = rel_r + 5'd1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n || blk_end) begin
      offset_r      <= '0;
      header_ok_r   <= 1'b1;
      maker_r       <= '0;
      product_r     <= '0;
      serial_r      <= '0;
      year_r        <= '0;
      width_lo_r    <= '0;
      width_hi_r    <= '0;
      height_lo_r   <= '0;
      height_hi_r   <= '0;
      rel_r         <= '0;
      prefix_zero_r <= 1'b0;
      target_r      <= TGT_NONE;
      stopped_r     <= 1'b0;
    end else begin
      offset_r      <= offset_nxt;
      header_ok_r   <= header_ok_nxt;
      maker_r       <= maker_nxt;
      product_r     <= product_nxt;
      serial_r      <= serial_nxt;
      year_r        <= year_nxt;
      width_lo_r    <= width_lo_nxt;
      width_hi_r    <= width_hi_nxt;
      height_lo_r   <= height_lo_nxt;
      height_hi_r   <= height_hi_nxt;
      rel_r         <= rel_nxt;
      prefix_zero_r <= prefix_zero_nxt;
      target_r      <= target_nxt;
      stopped_r     <= stopped_nxt;
    end
  end

  // Only bytes below the descriptors and the final byte count; text is already settled.
  assign res_valid = (offset_r >= OFF_LAST_BYTE) && header_ok_r;
  assign letters   = {3'b010, maker_r[14:10], 3'b010, maker_r[9:5], 3'b010, maker_r[4:0]};
  assign year_full = YEAR_BASE + {4'b0000, year_r};

  assign out_valid_nxt = blk_end || (out_valid_r && !out_tready);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (blk_end) begin
      out_user_r <= res_valid;
      if (res_valid) begin
        out_data_r <= {4'b0000, serial_hi, serial_lo, name_hi, name_lo,
                       height_hi_r, height_lo_r, width_hi_r, width_lo_r,
                       year_full, serial_r, product_r, letters};
      end else begin
        out_data_r <= '0;
      end
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;
  assign out_tuser  = out_user_r;

  a_final_loads_result: assert property (@(posedge clk) disable iff (!rst_n)
    blk_end |=> out_valid_r)
    else $error("final byte did not load a result");

  a_block_restarts: assert property (@(posedge clk) disable iff (!rst_n)
    blk_end |=> (offset_r == 8'd0 && target_r == TGT_NONE))
    else $error("parser state not cleared after final byte");

  a_target_needs_prefix: assert property (@(posedge clk) disable iff (!rst_n)
    (target_r != TGT_NONE) |-> prefix_zero_r)
    else $error("text target set without zero descriptor prefix");

  a_stall_cause: assert property (@(posedge clk) disable iff (!rst_n)
    !in_tready |-> (s1_valid_r && s1_last_r && out_valid_r && !out_tready))
    else $error("input stalled without a pending result");

  a_offset_saturates: assert property (@(posedge clk) disable iff (!rst_n)
    offset_r[7] |=> (offset_r[7] || $past(blk_end)))
    else $error("byte offset left saturation without block end");

endmodule

// ----- tb/tb_edid_base_block_parser_top.sv -----
// Self-checking testbench for the EDID base block parser: byte stream in, decoded block out.
`timescale 1ns / 100ps

module tb_edid_base_block_parser_top;
  import edid_pkg::*;

  localparam int BLOCK_BYTES  = 128;
  localparam int DESC_BYTES   = 18;
  localparam int NAME_SLOT    = 0;
  localparam int SERIAL_SLOT  = 1;
  localparam logic [7:0] HDR_FIRST = 8'h00;
  localparam logic [7:0] HDR_FILL  = 8'hFF;
  localparam int HOLD_CYCLES  = 400;
  localparam int DRAIN_CYCLES = 8;
  localparam int PHASE_BYTES  = 48;
  localparam int PHASE_BLOCKS = 1;
  localparam int CYCLE_LIMIT  = 200000;

  typedef struct packed {
    logic        valid;
    logic [23:0] maker_letters;
    logic [15:0] prod_id;
    logic [31:0] serial_id;
    logic [11:0] year;
    logic [11:0] hsize;
    logic [11:0] vsize;
    logic [63:0] name_low;
    logic [39:0] name_high;
    logic [63:0] serial_low;
    logic [39:0] serial_high;
  } edid_result_t;

  logic             clk        = 1'b0;
  logic             rst_n      = 1'b0;
  logic             in_tvalid  = 1'b0;
  logic             in_tready;
  logic [7:0]       in_tdata   = '0;
  logic             in_tlast   = 1'b0;
  logic             out_tvalid;
  logic             out_tready = 1'b0;
  logic [OUT_W-1:0] out_tdata;
  logic             out_tuser;

  edid_base_block_parser_top dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tlast   (in_tlast),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser)
  );

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  // Expected decoded blocks, oldest first
  edid_result_t decoded_q[$];
  logic [7:0]   block_q[$];

  int tx_idle_pct = 0;
  int rx_idle_pct = 0;
  int hold_reqs   = 0;
  int hold_seen   = 0;
  int hold_left   = 0;
  int mismatches  = 0;
  int bytes_sent  = 0;
  int blocks_sent = 0;
  int good_seen   = 0;
  int bad_seen    = 0;
  int unsigned cycle_count = 0;

  // Parser state mirrored by the predictor
  int           blk_offset;
  logic         hdr_ok;
  logic [15:0]  maker_raw;
  logic [15:0]  product_raw;
  logic [31:0]  serial_raw;
  logic [7:0]   year_off;
  logic [7:0]   t56, t58, t59, t61;
  logic         prefix_zero;
  text_target_t desc_target;
  logic         text_stopped;
  logic [7:0]   txt_chars [2][TEXT_CHARS];
  int           txt_count [2];
  int           txt_kept  [2];

  task automatic clear_parse_state();
    blk_offset   = 0;
    hdr_ok       = 1'b1;
    maker_raw    = '0;
    product_raw  = '0;
    serial_raw   = '0;
    year_off     = '0;
    t56 = '0; t58 = '0; t59 = '0; t61 = '0;
    prefix_zero  = 1'b0;
    desc_target  = TGT_NONE;
    text_stopped = 1'b0;
    for (int s = 0; s < 2; s++) begin
      txt_count[s] = 0;
      txt_kept[s]  = 0;
      for (int k = 0; k < TEXT_CHARS; k++) txt_chars[s][k] = '0;
    end
  endtask

  task automatic parse_edid_byte(input logic [7:0] b, input logic last);
    int r;
    int s;
    logic [63:0] lo [2];
    logic [39:0] hi [2];
    edid_result_t res;
    if (blk_offset < BLOCK_BYTES) begin
      if (blk_offset == 0 && b != HDR_FIRST) hdr_ok = 1'b0;
      if (blk_offset >= 1 && blk_offset <= 3 && b != HDR_FILL) hdr_ok = 1'b0;
      case (blk_offset)
        8:  maker_raw[15:8]  = b;
        9:  maker_raw[7:0]   = b;
        10: product_raw[7:0] = b;
        11: product_raw[15:8] = b;
        12, 13, 14, 15: serial_raw[8 * (blk_offset - 12) +: 8] = b;
        17: year_off = b;
        56: t56 = b;
        58: t58 = b;
        59: t59 = b;
        61: t61 = b;
        default: ;
      endcase
      if (blk_offset >= OFF_DESC_BASE && blk_offset < OFF_DESC_END) begin
        r = (blk_offset - OFF_DESC_BASE) % DESC_BYTES;
        s = (desc_target == TGT_SERIAL) ? SERIAL_SLOT : NAME_SLOT;
        if (r == 0) begin
          prefix_zero  = (b == 8'h00);
          desc_target  = TGT_NONE;
          text_stopped = 1'b0;
        end else if (r <= 2) begin
          if (b != 8'h00) prefix_zero = 1'b0;
        end else if (r == DESC_REL_TAG) begin
          if (prefix_zero && (b == TAG_NAME || b == TAG_SERIAL)) begin
            if (b == TAG_NAME) begin
              desc_target = TGT_NAME;
              s = NAME_SLOT;
            end else begin
              desc_target = TGT_SERIAL;
              s = SERIAL_SLOT;
            end
            txt_count[s] = 0;
            txt_kept[s]  = 0;
            for (int k = 0; k < TEXT_CHARS; k++) txt_chars[s][k] = '0;
          end
        end else if (r >= DESC_REL_TEXT && !text_stopped && desc_target != TGT_NONE) begin
          if (b == CH_LF || b == CH_NUL || txt_count[s] >= TEXT_CHARS) begin
            text_stopped = 1'b1;
          end else if (b >= CH_SPACE && b <= CH_TILDE) begin
            txt_chars[s][txt_count[s]] = b;
            txt_count[s]++;
            // trailing spaces never move the kept length
            if (b != CH_SPACE) txt_kept[s] = txt_count[s];
            if (txt_count[s] >= TEXT_CHARS) text_stopped = 1'b1;
          end
        end
        if (r == DESC_REL_LAST) desc_target = TGT_NONE;
      end
      blk_offset++;
    end
    if (last) begin
      res = '0;
      res.valid = (blk_offset >= BLOCK_BYTES) && hdr_ok;
      if (res.valid) begin
        res.maker_letters = {8'h40 + 8'(maker_raw[14:10]), 8'h40 + 8'(maker_raw[9:5]),
                             8'h40 + 8'(maker_raw[4:0])};
        res.prod_id   = product_raw;
        res.serial_id = serial_raw;
        res.year      = YEAR_BASE + 12'(year_off);
        res.hsize     = {t58[7:4], t56};
        res.vsize     = {t61[7:4], t59};
        for (int t = 0; t < 2; t++) begin
          lo[t] = '0;
          hi[t] = '0;
          for (int k = 0; k < txt_kept[t]; k++) begin
            if (k < 8) lo[t][8 * k +: 8] = txt_chars[t][k];
            else       hi[t][8 * (k - 8) +: 8] = txt_chars[t][k];
          end
        end
        res.name_low    = lo[NAME_SLOT];
        res.name_high   = hi[NAME_SLOT];
        res.serial_low  = lo[SERIAL_SLOT];
        res.serial_high = hi[SERIAL_SLOT];
      end
      decoded_q.push_back(res);
      clear_parse_state();
    end
  endtask

  task automatic report_mismatch(input string what, input logic [63:0] got,
                                 input logic [63:0] want);
    if (mismatches < 40)
      $display("[%0t] %s: got %h, expected %h", $realtime, what, got, want);
    mismatches++;
  endtask

  task automatic check_field(input string what, input logic [63:0] got,
                             input logic [63:0] want);
    if (got !== want) report_mismatch(what, got, want);
  endtask

  // Result checker
  always @(posedge clk) begin
    edid_result_t want;
    if (rst_n && out_tvalid && out_tready) begin
      if (decoded_q.size() == 0) begin
        report_mismatch("result with none pending", 64'(out_tuser), '0);
      end else begin
        want = decoded_q.pop_front();
        if (want.valid) good_seen++;
        else bad_seen++;
        check_field("valid_res",        64'(out_tuser),         64'(want.valid));
        check_field("maker_letters",    64'(out_tdata[23:0]),   64'(want.maker_letters));
        check_field("prod_id",          64'(out_tdata[39:24]),  64'(want.prod_id));
        check_field("serial_id",        64'(out_tdata[71:40]),  64'(want.serial_id));
        check_field("year",             64'(out_tdata[83:72]),  64'(want.year));
        check_field("hsize",            64'(out_tdata[95:84]),  64'(want.hsize));
        check_field("vsize",            64'(out_tdata[107:96]), 64'(want.vsize));
        check_field("name_text_low",    out_tdata[171:108],     want.name_low);
        check_field("name_text_high",   64'(out_tdata[211:172]), 64'(want.name_high));
        check_field("serial_text_low",  out_tdata[275:212],     want.serial_low);
        check_field("serial_text_high", 64'(out_tdata[315:276]), 64'(want.serial_high));
      end
    end
  end

  // Receiver: random stalls, plus a long hold-off on request
  always @(posedge clk) begin
    if (!rst_n) begin
      out_tready <= 1'b0;
    end else if (hold_left > 0) begin
      out_tready <= 1'b0;
      hold_left  <= hold_left - 1;
    end else if (hold_seen != hold_reqs) begin
      hold_seen  <= hold_reqs;
      hold_left  <= HOLD_CYCLES;
      out_tready <= 1'b0;
    end else begin
      out_tready <= ($urandom_range(99) >= rx_idle_pct);
    end
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("edid_base_block_parser_top: mismatch");
      $finish;
    end
  end

  task automatic send_byte(input logic [7:0] b, input logic last);
    while ($urandom_range(99) < tx_idle_pct) begin
      in_tvalid <= 1'b0;
      @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= b;
    in_tlast  <= last;
    do @(posedge clk); while (!in_tready);
    bytes_sent++;
    parse_edid_byte(b, last);
  endtask

  task automatic send_block();
    for (int i = 0; i < block_q.size(); i++) send_byte(block_q[i], i == block_q.size() - 1);
    blocks_sent++;
  endtask

  task automatic start_block(input logic [7:0] fill);
    block_q.delete();
    repeat (BLOCK_BYTES) block_q.push_back(fill);
    block_q[0] = HDR_FIRST;
    for (int i = 1; i < 4; i++) block_q[i] = HDR_FILL;
  endtask

  // Write a display descriptor: zero prefix, tag, then text from the first text byte
  task automatic put_text(input int base, input logic [7:0] tag, input string s);
    for (int i = 0; i < 3; i++) block_q[base + i] = 8'h00;
    block_q[base + DESC_REL_TAG] = tag;
    block_q[base + 4] = 8'h00;
    for (int i = 0; i < s.len(); i++) block_q[base + DESC_REL_TEXT + i] = s[i];
  endtask

  task automatic build_random_block();
    int pick;
    int base;
    int roll;
    int len;
    logic [7:0] ch;
    block_q.delete();
    repeat (BLOCK_BYTES) block_q.push_back(8'($urandom_range(255)));
    block_q[0] = HDR_FIRST;
    for (int i = 1; i < 4; i++) block_q[i] = HDR_FILL;
    if ($urandom_range(9) == 0) begin
      pick = $urandom_range(3);
      block_q[pick] = block_q[pick] ^ (8'h01 << $urandom_range(7));
    end
    for (int d = 0; d < 4; d++) begin
      base = OFF_DESC_BASE + DESC_BYTES * d;
      pick = $urandom_range(9);
      if (pick <= 6) begin
        for (int i = 0; i < 3; i++) block_q[base + i] = 8'h00;
        block_q[base + DESC_REL_TAG] = $urandom_range(1) ? TAG_NAME : TAG_SERIAL;
        // near miss: one prefix byte nonzero
        if (pick >= 5) block_q[base + $urandom_range(2)] = 8'($urandom_range(1, 255));
        for (int i = DESC_REL_TEXT; i < DESC_BYTES; i++) begin
          roll = $urandom_range(99);
          if (roll < 55)      ch = 8'($urandom_range(8'h21, 8'h7E));
          else if (roll < 75) ch = CH_SPACE;
          else if (roll < 82) ch = CH_LF;
          else if (roll < 86) ch = CH_NUL;
          else                ch = 8'($urandom_range(255));
          block_q[base + i] = ch;
        end
      end else if (pick == 7) begin
        for (int i = 0; i < 3; i++) block_q[base + i] = 8'h00;
      end
    end
    pick = $urandom_range(99);
    if (pick < 10) begin
      repeat ($urandom_range(1, 12)) block_q.push_back(8'($urandom_range(255)));
    end else if (pick >= 65) begin
      len = $urandom_range(1) ? $urandom_range(1, 16) : $urandom_range(17, BLOCK_BYTES - 1);
      while (block_q.size() > len) void'(block_q.pop_back());
    end
  endtask

  task automatic test_short_blocks();
    block_q.delete();
    block_q.push_back(8'h00);
    send_block();
    start_block(8'h00);
    void'(block_q.pop_back());
    send_block();
  endtask

  // Corrupt the first and the last header byte; random blocks hit the others
  task automatic test_header_check();
    for (int p = 0; p < 4; p += 3) begin
      start_block(8'h11);
      block_q[p] = (p == 0) ? 8'h80 : 8'h7F;
      send_block();
    end
  endtask

  task automatic test_field_decode();
    start_block(8'h00);
    send_block();
    // all ones: maker top bit ignored, every numeric field at its maximum
    start_block(8'hFF);
    send_block();
    start_block(8'h00);
    for (int i = 4; i < BLOCK_BYTES; i++) block_q[i] = 8'(i * 37);
    send_block();
  endtask

  task automatic test_descriptor_text();
    start_block(8'h01);
    put_text(54, TAG_SERIAL, "EARLY");
    block_q[54 + DESC_REL_TEXT + 5] = CH_LF;
    put_text(72, TAG_NAME, "Panel 27  ");
    block_q[72 + DESC_REL_TEXT + 10] = CH_LF;
    put_text(90, TAG_SERIAL, "ABCDEFGHIJKLM");
    put_text(108, TAG_NAME, "X Y");
    block_q[108 + 8]  = 8'h7F;
    block_q[108 + 9]  = 8'h1F;
    block_q[108 + 10] = 8'h80;
    block_q[108 + 11] = CH_TILDE;
    block_q[108 + 12] = CH_NUL;
    block_q[108 + 13] = 8'h41;
    send_block();
    start_block(CH_SPACE);
    put_text(54, TAG_NAME, "Panel 27");
    put_text(72, TAG_NAME, "WRONG");
    block_q[73] = 8'h01;
    put_text(90, TAG_SERIAL, "SN 0042");
    block_q[90 + DESC_REL_TEXT + 7] = CH_NUL;
    put_text(108, 8'hFD, "IGNORED");
    send_block();
  endtask

  task automatic test_excess_bytes();
    start_block(8'h5A);
    for (int i = 0; i < 12; i++) block_q.push_back(i[0] ? 8'hFF : 8'h00);
    send_block();
  endtask

  task automatic test_random_traffic(input int tx, input int rx);
    int first_bytes;
    int first_blocks;
    tx_idle_pct  = tx;
    rx_idle_pct  = rx;
    first_bytes  = bytes_sent;
    first_blocks = blocks_sent;
    while (bytes_sent - first_bytes < PHASE_BYTES || blocks_sent - first_blocks < PHASE_BLOCKS)
    begin
      build_random_block();
      send_block();
    end
  endtask

  // Hold the output off while short blocks keep coming, so the input backs up
  task automatic test_output_stall();
    tx_idle_pct = 0;
    rx_idle_pct = 0;
    in_tvalid <= 1'b0;
    hold_reqs <= hold_reqs + 1;
    @(posedge clk);
    for (int n = 0; n < 6; n++) begin
      block_q.delete();
      repeat (3) block_q.push_back(8'($urandom_range(255)));
      send_block();
    end
    start_block(8'hC3);
    send_block();
  endtask

  initial begin
    clear_parse_state();
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    tx_idle_pct = 19;
    rx_idle_pct = 64;
    test_short_blocks();
    test_header_check();
    test_field_decode();
    test_descriptor_text();
    test_excess_bytes();
    test_random_traffic(19, 64);
    test_random_traffic(64, 19);
    test_output_stall();
    test_random_traffic(0, 0);

    in_tvalid <= 1'b0;
    while (decoded_q.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    $display("Sent %0d bytes in %0d blocks; checked %0d accepted and %0d rejected blocks.",
             bytes_sent, blocks_sent, good_seen, bad_seen);
    $display("Covered header faults, short and overlong blocks, text descriptors, stalls.");
    if (mismatches == 0 && decoded_q.size() == 0) begin
      $display("edid_base_block_parser_top: match");
    end else begin
      $display("edid_base_block_parser_top: mismatch");
    end
    $finish;
  end

endmodule

// ----- sim.f -----
hdl/edid_pkg.sv
hdl/edid_text_cap.sv
hdl/edid_base_block_parser_top.sv
tb/tb_edid_base_block_parser_top.sv
